>>> hw/rtl/chd_pkg.sv
// Shared types and constants for the canonical Huffman decoder.
// Holds opcodes, state codes, the prefix comparison type and its step function.
// No dependencies.
package chd_pkg;

	// Field widths fixed by the item format
	localparam int unsigned OPC_W     = 2;
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned LEN_IN_W  = 6;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned SYM_W     = 8;
	localparam int unsigned TOTAL_W   = 48;
	localparam int unsigned IN_DATA_W = 24;
	localparam int unsigned BIT_CNT_W = 4;
	localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [OPC_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_SET_LEN = 2'd1,
		OP_START   = 2'd2,
		OP_DATA    = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LONE,
		ST_PREFIX,
		ST_PLACE,
		ST_BIT,
		ST_POS,
		ST_SYM,
		ST_FLUSH
	} state_t;

	// Path so far versus the same-depth prefix of a range bound
	typedef enum logic [1:0] {
		CMP_EQ,
		CMP_LT,
		CMP_GT
	} cmp_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             done;
	} result_t;

	// One MSB-first step of a serial magnitude compare
	function automatic cmp_t cmp_step(cmp_t cur, logic b, logic r);
		cmp_t res;
		res = cur;
		if (cur == CMP_EQ) begin
			if (b && !r) begin
				res = CMP_GT;
			end else if (!b && r) begin
				res = CMP_LT;
			end
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/canonical_huffman_decoder.sv
// Canonical Huffman decoder over a byte alphabet: length table, canonical build, bit-serial decode.
// Depends on chd_pkg (types, opcodes, serial compare step).
// Holds the length table and the sorted symbol memory as internal arrays.

// Items come in on the s_ side with the opcode in s_tuser. Clear and set-length items are
// taken while idle and leave the state alone. A start item runs the canonical build: one
// sweep over the length table to count codes per length, the lone-symbol fix, a pass over
// the lengths to hand out first codes and offsets, and a second sweep that writes the sorted
// symbol memory. A data byte is walked one bit per cycle while no completed code is pending,
// MSB first, against per-length serial comparators that track whether the current path still
// leads to a code. A bit that completes a code pauses the walk for the address computation
// and sorted-memory read (ST_POS), then for the hand-over of the symbol (ST_SYM), which
// waits while m_tready holds results back. One decoded symbol is held back until the next
// one or the end of the byte is known, so tlast marks the last symbol of each byte. tuser on
// the output flags the symbol that brings the decoded count to total_symbols; bytes after
// that give nothing until the next start.
module canonical_huffman_decoder #(
	parameter int unsigned ALPHABET_SIZE = 256,
	parameter int unsigned MAX_CODE_LEN  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [chd_pkg::IN_DATA_W-1:0] s_tdata,   // symbol_index[7:0], code_length[13:8],
	                                                 // data_byte[21:14], zero[23:22]
	input  logic [chd_pkg::OPC_W-1:0]     s_tuser,   // opcode[1:0]
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [chd_pkg::SYM_W-1:0]     m_tdata,   // symbol[7:0]
	output logic                          m_tlast,   // last_of_byte
	output logic [0:0]                    m_tuser,   // stream_done[0]
	// total_symbols register
	input  logic                          cfg_we,
	input  logic [chd_pkg::TOTAL_W-1:0]   cfg_wdata
);

	localparam int unsigned A     = ALPHABET_SIZE;
	localparam int unsigned M     = MAX_CODE_LEN;
	localparam int unsigned LW    = $clog2(M + 1);
	localparam int unsigned EW    = LW + 1;
	localparam int unsigned BW    = $clog2(M);
	localparam int unsigned CNT_W = $clog2(A + 1);
	localparam int unsigned PW    = $clog2(A);
	localparam int unsigned SW    = PW + 1;

	// ---------------------------------------------------------------- declarations
	chd_pkg::state_t  state_q, state_d;
	chd_pkg::opcode_t in_op;
	logic [chd_pkg::IDX_W-1:0]    in_idx;
	logic [chd_pkg::LEN_IN_W-1:0] in_len;
	logic [chd_pkg::BYTE_W-1:0]   in_byte;
	logic                         accept;
	logic                         idx_ok;
	logic [LW-1:0]                len_clamped;

	logic [chd_pkg::TOTAL_W-1:0]  total_q;

	// length table: memory plus per-entry valid bits (cleared entries read as zero)
	logic [LW-1:0] len_mem [A];
	logic [A-1:0]  len_vld_q;
	logic [LW-1:0] len_rd_s1;
	logic          len_vld_s1;
	logic          rd_pend_s1;
	logic [PW-1:0] rd_sym_s1;
	logic [LW-1:0] len_rd;
	logic          rd_issue;
	logic [SW-1:0] scan_q;
	logic          scan_end;

	// build state
	logic [CNT_W-1:0] present_q;
	logic             lone_q;
	logic             lone_w;
	logic [LW-1:0]    lidx_q;
	logic [M-1:0]     code_q;
	logic             started_q;
	logic [CNT_W-1:0] offacc_q;
	logic [CNT_W-1:0] cur_cnt;
	logic [M-1:0]     c_sh;
	logic [M-1:0]     lmask;
	logic [M-1:0]     lo_v;
	logic [M:0]       sum_v;
	logic [M-1:0]     hi_v;
	logic             wrap_v;
	logic             full_v;

	// per-length tables
	logic [CNT_W-1:0] cnt_q    [1:M];
	logic [CNT_W-1:0] off_q    [1:M];
	logic [CNT_W-1:0] fill_q   [1:M];
	logic [CNT_W-1:0] lo_low_q [1:M];
	logic [M-1:0]     lo_al_q  [1:M];
	logic [M-1:0]     hi_al_q  [1:M];
	logic [M:1]       full_q;
	logic [M:1]       wrap_q;

	// placement sweep
	logic [LW-1:0]    l_eff;
	logic [CNT_W-1:0] place_off;
	logic [CNT_W-1:0] place_fill;
	logic [CNT_W-1:0] place_sum;
	logic             place_wr;

	// sorted symbol memory
	logic [chd_pkg::SYM_W-1:0] sorted_mem [A];
	logic [chd_pkg::SYM_W-1:0] sym_rd_q;

	// bit-serial decode
	logic                             tables_ready_q;
	logic [LW-1:0]                    plen_q;
	logic [CNT_W-1:0]                 pval_q;
	logic [chd_pkg::TOTAL_W-1:0]      decoded_q;
	logic [chd_pkg::BYTE_W-1:0]       byte_q;
	logic [chd_pkg::BIT_CNT_W-1:0]    bits_q;
	chd_pkg::cmp_t                    clo_q [1:M];
	chd_pkg::cmp_t                    chi_q [1:M];
	chd_pkg::cmp_t                    nclo  [1:M];
	chd_pkg::cmp_t                    nchi  [1:M];
	logic [M:1]                       lane_ok;
	logic [EW-1:0]                    e_w;
	logic [EW-1:0]                    bidx_w;
	logic [BW-1:0]                    bidx;
	logic                             cur_bit;
	logic                             stop;
	logic                             bit_go;
	logic                             any_ok;
	logic                             hit;
	logic                             commit;
	logic                             hit_fire;
	logic [LW-1:0]                    hit_len_q;
	logic [CNT_W-1:0]                 hit_q;
	logic                             hit_done_q;

	// address of the decoded symbol
	logic [CNT_W-1:0] pos_cnt;
	logic [CNT_W-1:0] pos_off;
	logic [CNT_W-1:0] pos_lo;
	logic [CNT_W-1:0] pos_mask;
	logic [CNT_W-1:0] pos_d;
	logic [CNT_W-1:0] pos_extra;
	logic [CNT_W-1:0] pos_sum;
	logic [PW-1:0]    pos_addr;

	// held result and output register
	chd_pkg::result_t          pend_q;
	logic                      pend_vld_q;
	logic                      sym_go;
	logic                      push;
	logic                      push_last;
	logic                      out_free;
	logic                      m_tvalid_q;
	logic [chd_pkg::SYM_W-1:0] m_sym_q;
	logic                      m_last_q;
	logic                      m_done_q;

	// ---------------------------------------------------------------- input unpacking
	assign in_op   = chd_pkg::opcode_t'(s_tuser);
	assign in_idx  = s_tdata[7:0];
	assign in_len  = s_tdata[13:8];
	assign in_byte = s_tdata[21:14];
	assign accept  = s_tvalid && s_tready;
	assign idx_ok  = ({1'b0, in_idx} < (chd_pkg::IDX_W + 1)'(A));
	assign len_clamped = (in_len > chd_pkg::LEN_IN_W'(M)) ? LW'(M) : LW'(in_len);

	// ---------------------------------------------------------------- control FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		sym_go    = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		case (state_q)
			chd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_op == chd_pkg::OP_START) begin
						state_d = chd_pkg::ST_SCAN;
					end else if (in_op == chd_pkg::OP_DATA && tables_ready_q) begin
						state_d = chd_pkg::ST_BIT;
					end
				end
			end
			chd_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = chd_pkg::ST_LONE;
				end
			end
			chd_pkg::ST_LONE: begin
				state_d = chd_pkg::ST_PREFIX;
			end
			chd_pkg::ST_PREFIX: begin
				if (lidx_q == LW'(M)) begin
					state_d = chd_pkg::ST_PLACE;
				end
			end
			chd_pkg::ST_PLACE: begin
				if (scan_end) begin
					state_d = chd_pkg::ST_IDLE;
				end
			end
			chd_pkg::ST_BIT: begin
				if (stop) begin
					state_d = chd_pkg::ST_FLUSH;
				end else if (hit_fire) begin
					state_d = chd_pkg::ST_POS;
				end
			end
			chd_pkg::ST_POS: begin
				state_d = chd_pkg::ST_SYM;
			end
			chd_pkg::ST_SYM: begin
				// the held symbol is not the last of the byte: send it on
				if (!pend_vld_q || out_free) begin
					sym_go  = 1'b1;
					push    = pend_vld_q;
					state_d = chd_pkg::ST_BIT;
				end
			end
			chd_pkg::ST_FLUSH: begin
				if (!pend_vld_q) begin
					state_d = chd_pkg::ST_IDLE;
				end else if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = chd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = chd_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- register and table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (accept && in_op == chd_pkg::OP_CLEAR) begin
			len_vld_q <= '0;
		end else if (accept && in_op == chd_pkg::OP_SET_LEN && idx_ok) begin
			len_vld_q[in_idx[PW-1:0]] <= 1'b1;
		end
	end

	assign rd_issue = (state_q == chd_pkg::ST_SCAN || state_q == chd_pkg::ST_PLACE)
		&& (scan_q < SW'(A));
	assign scan_end = (scan_q == SW'(A)) && !rd_pend_s1;
	assign len_rd   = len_vld_s1 ? len_rd_s1 : '0;

	always_ff @(posedge clk) begin
		if (accept && in_op == chd_pkg::OP_SET_LEN && idx_ok) begin
			len_mem[in_idx[PW-1:0]] <= len_clamped;
		end
		if (rd_issue) begin
			len_rd_s1  <= len_mem[scan_q[PW-1:0]];
			len_vld_s1 <= len_vld_q[scan_q[PW-1:0]];
			rd_sym_s1  <= scan_q[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_issue;
			if ((accept && in_op == chd_pkg::OP_START) || state_q == chd_pkg::ST_PREFIX) begin
				scan_q <= '0;
			end else if (rd_issue) begin
				scan_q <= scan_q + SW'(1);
			end
		end
	end

	// ---------------------------------------------------------------- canonical build
	assign lone_w = (present_q == CNT_W'(1));

	always_comb begin
		cur_cnt = '0;
		for (int L = 1; L <= M; L++) begin
			if (lidx_q == LW'(L)) begin
				cur_cnt = cnt_q[L];
			end
		end
		c_sh   = started_q ? {code_q[M-2:0], 1'b0} : code_q;
		lmask  = {M{1'b1}} >> (M - int'(lidx_q));
		lo_v   = c_sh & lmask;
		sum_v  = {1'b0, lo_v} + (M + 1)'(cur_cnt) - (M + 1)'(1);
		hi_v   = sum_v[M-1:0] & lmask;
		wrap_v = |(sum_v >> lidx_q);
		full_v = |(cur_cnt >> lidx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q      <= '0;
			lone_q         <= 1'b0;
			lidx_q         <= '0;
			code_q         <= '0;
			started_q      <= 1'b0;
			offacc_q       <= '0;
			tables_ready_q <= 1'b0;
		end else begin
			if (accept && in_op == chd_pkg::OP_START) begin
				present_q <= '0;
			end else if (state_q == chd_pkg::ST_SCAN && rd_pend_s1 && len_rd != '0) begin
				present_q <= present_q + CNT_W'(1);
			end
			if (state_q == chd_pkg::ST_LONE) begin
				lone_q    <= lone_w;
				lidx_q    <= LW'(1);
				code_q    <= '0;
				started_q <= 1'b0;
				offacc_q  <= '0;
			end else if (state_q == chd_pkg::ST_PREFIX) begin
				lidx_q   <= lidx_q + LW'(1);
				offacc_q <= offacc_q + cur_cnt;
				if (cur_cnt != '0) begin
					code_q    <= c_sh + M'(cur_cnt);
					started_q <= 1'b1;
				end else begin
					code_q <= c_sh;
				end
			end
			if (state_q == chd_pkg::ST_PLACE && scan_end) begin
				tables_ready_q <= (present_q != '0);
			end
		end
	end

	always_comb begin
		l_eff      = lone_q ? LW'(1) : len_rd;
		place_off  = '0;
		place_fill = '0;
		for (int L = 1; L <= M; L++) begin
			if (l_eff == LW'(L)) begin
				place_off  = off_q[L];
				place_fill = fill_q[L];
			end
		end
		place_sum = place_off + place_fill;
		place_wr  = (state_q == chd_pkg::ST_PLACE) && rd_pend_s1 && (len_rd != '0);
	end

	always_ff @(posedge clk) begin
		for (int L = 1; L <= M; L++) begin
			if (accept && in_op == chd_pkg::OP_START) begin
				cnt_q[L] <= '0;
			end else if (state_q == chd_pkg::ST_SCAN && rd_pend_s1 && len_rd == LW'(L)) begin
				cnt_q[L] <= cnt_q[L] + CNT_W'(1);
			end else if (state_q == chd_pkg::ST_LONE && lone_w) begin
				// a lone symbol is coded as length 1, code 0
				cnt_q[L] <= (L == 1) ? CNT_W'(1) : '0;
			end
			if (state_q == chd_pkg::ST_PREFIX && lidx_q == LW'(L)) begin
				off_q[L]    <= offacc_q;
				fill_q[L]   <= '0;
				lo_low_q[L] <= lo_v[CNT_W-1:0];
				lo_al_q[L]  <= lo_v << (M - L);
				hi_al_q[L]  <= hi_v << (M - L);
				full_q[L]   <= full_v;
				wrap_q[L]   <= wrap_v;
			end else if (place_wr && l_eff == LW'(L)) begin
				fill_q[L] <= fill_q[L] + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (place_wr) begin
			sorted_mem[place_sum[PW-1:0]] <= chd_pkg::SYM_W'(rd_sym_s1);
		end
		if (state_q == chd_pkg::ST_POS) begin
			sym_rd_q <= sorted_mem[pos_addr];
		end
	end

	// ---------------------------------------------------------------- bit-serial tree walk
	// Each length keeps where the path stands against the prefixes of its lowest and highest
	// code; the node exists if any length at or below the depth still has a code under it.
	assign e_w     = EW'(plen_q) + EW'(1);
	assign bidx_w  = EW'(M) - e_w;
	assign bidx    = bidx_w[BW-1:0];
	assign cur_bit = byte_q[chd_pkg::BYTE_W-1];
	assign stop    = (decoded_q >= total_q) || (bits_q == '0);
	assign bit_go  = (state_q == chd_pkg::ST_BIT) && !stop;

	always_comb begin
		logic in_rng;
		for (int L = 1; L <= M; L++) begin
			nclo[L] = chd_pkg::cmp_step(clo_q[L], cur_bit, lo_al_q[L][bidx]);
			nchi[L] = chd_pkg::cmp_step(chi_q[L], cur_bit, hi_al_q[L][bidx]);
			if (wrap_q[L]) begin
				in_rng = (nclo[L] != chd_pkg::CMP_LT) || (nchi[L] != chd_pkg::CMP_GT);
			end else begin
				in_rng = (nclo[L] != chd_pkg::CMP_LT) && (nchi[L] != chd_pkg::CMP_GT);
			end
			lane_ok[L] = (EW'(L) >= e_w) && (cnt_q[L] != '0) && (full_q[L] || in_rng);
		end
		any_ok = 1'b0;
		hit    = 1'b0;
		for (int L = 1; L <= M; L++) begin
			any_ok = any_ok | lane_ok[L];
			if (EW'(L) == e_w) begin
				hit = lane_ok[L];
			end
		end
	end

	// dead bits and bits past the longest length leave the position alone
	assign commit   = bit_go && (e_w <= EW'(M)) && any_ok;
	assign hit_fire = commit && hit;

	always_ff @(posedge clk) begin
		for (int L = 1; L <= M; L++) begin
			if ((accept && in_op == chd_pkg::OP_START) || hit_fire) begin
				clo_q[L] <= chd_pkg::CMP_EQ;
				chi_q[L] <= chd_pkg::CMP_EQ;
			end else if (commit) begin
				clo_q[L] <= nclo[L];
				chi_q[L] <= nchi[L];
			end
		end
		if (accept && in_op == chd_pkg::OP_DATA) begin
			byte_q <= in_byte;
		end else if (bit_go) begin
			byte_q <= {byte_q[chd_pkg::BYTE_W-2:0], 1'b0};
		end
		if (hit_fire) begin
			hit_len_q  <= e_w[LW-1:0];
			hit_q      <= {pval_q[CNT_W-2:0], cur_bit};
			hit_done_q <= ((decoded_q + chd_pkg::TOTAL_W'(1)) == total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			pval_q    <= '0;
			decoded_q <= '0;
			bits_q    <= '0;
		end else begin
			if ((accept && in_op == chd_pkg::OP_START) || hit_fire) begin
				plen_q <= '0;
				pval_q <= '0;
			end else if (commit) begin
				plen_q <= e_w[LW-1:0];
				pval_q <= {pval_q[CNT_W-2:0], cur_bit};
			end
			if (accept && in_op == chd_pkg::OP_START) begin
				decoded_q <= '0;
			end else if (hit_fire) begin
				decoded_q <= decoded_q + chd_pkg::TOTAL_W'(1);
			end
			if (accept && in_op == chd_pkg::OP_DATA) begin
				bits_q <= chd_pkg::BITS_PER_BYTE;
			end else if (bit_go) begin
				bits_q <= bits_q - chd_pkg::BIT_CNT_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- symbol address
	// Offset of the length plus the code's rank in it; with more codes than the length can
	// hold, the last of the clashing ones is taken.
	always_comb begin
		pos_cnt = '0;
		pos_off = '0;
		pos_lo  = '0;
		for (int L = 1; L <= M; L++) begin
			if (hit_len_q == LW'(L)) begin
				pos_cnt = cnt_q[L];
				pos_off = off_q[L];
				pos_lo  = lo_low_q[L];
			end
		end
		if (int'(hit_len_q) >= int'(CNT_W)) begin
			pos_mask = '1;
		end else begin
			pos_mask = ~({CNT_W{1'b1}} << hit_len_q);
		end
		pos_d = (hit_q - pos_lo) & pos_mask;
		if (int'(hit_len_q) < int'(CNT_W)) begin
			pos_extra = ((pos_cnt - CNT_W'(1) - pos_d) >> hit_len_q) << hit_len_q;
		end else begin
			pos_extra = '0;
		end
		pos_sum  = pos_off + pos_d + pos_extra;
		pos_addr = pos_sum[PW-1:0];
	end

	// ---------------------------------------------------------------- held result, output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (sym_go) begin
				pend_vld_q <= 1'b1;
			end else if (push_last) begin
				pend_vld_q <= 1'b0;
			end
			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sym_go) begin
			pend_q.symbol <= sym_rd_q;
			pend_q.done   <= hit_done_q;
		end
		if (push) begin
			m_sym_q  <= pend_q.symbol;
			m_last_q <= push_last;
			m_done_q <= pend_q.done;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_sym_q;
	assign m_tlast    = m_last_q;
	assign m_tuser[0] = m_done_q;

	// ---------------------------------------------------------------- assertions
`ifndef SYNTH
	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chd_pkg::ST_IDLE) |-> !pend_vld_q)
		else $error("symbol still held back while idle");

	a_hit_has_codes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chd_pkg::ST_POS) |-> (pos_cnt != '0))
		else $error("decoded length has no codes");

	a_walk_needs_tables: assert property (@(posedge clk) disable iff (!arst_n)
		!tables_ready_q |-> (state_q != chd_pkg::ST_BIT))
		else $error("bit walk without built tables");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chd_pkg::ST_BIT) |-> (plen_q <= LW'(M)))
		else $error("tree depth beyond longest code");
`endif

endmodule

>>> tb/sv/canonical_huffman_decoder_tb.sv
// Self-checking bench for canonical_huffman_decoder: loads code lengths, builds, decodes bytes.
// Keeps its own model of the length table, canonical build and bit walk; compares every symbol.
// Depends on chd_pkg (opcodes, field widths) and the canonical_huffman_decoder RTL.
module canonical_huffman_decoder_tb;
	import chd_pkg::*;

	localparam int unsigned ALPHA         = 256;
	localparam int unsigned MAX_LEN       = 32;
	// A start item sweeps the length table twice plus one pass over the lengths
	localparam int unsigned SETTLE_CYCLES = 2 * ALPHA + MAX_LEN + 160;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned LIMIT_CYCLES  = 300000;
	localparam int unsigned PHASES        = 6;
	localparam int unsigned RANDOM_ITEMS  = 230;

	typedef struct packed {
		opcode_t         op;
		logic [IDX_W-1:0]    idx;
		logic [LEN_IN_W-1:0] ln;
		logic [BYTE_W-1:0]   dbyte;
	} chd_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
		logic             done;
	} dec_out_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata   = '0;
	logic [OPC_W-1:0]     s_tuser   = OP_CLEAR;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [SYM_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic [0:0]           m_tuser;
	logic                 cfg_we    = 1'b0;
	logic [TOTAL_W-1:0]   cfg_wdata = '0;

	canonical_huffman_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Decoder model state
	// ---------------------------------------------------------------
	logic [LEN_IN_W-1:0] len_tab [ALPHA];     // lengths already clamped to MAX_LEN
	int unsigned         len_count [MAX_LEN+1];
	logic [31:0]         first_code [MAX_LEN+1];
	logic [SYM_W-1:0]    order_sym [ALPHA];   // symbols in canonical order
	logic [31:0]         path_val;
	int unsigned         path_len;
	logic [TOTAL_W-1:0]  n_decoded;
	logic [TOTAL_W-1:0]  sym_total;
	bit                  ready;

	chd_item_t items_to_send [$];
	dec_out_t  symbols_due [$];

	int unsigned n_pushed, n_items, n_results, n_builds, n_cfg, n_holds, n_errs;
	int unsigned hold_req, hold_ack;
	bit          idle_on;

	initial begin
		foreach (len_tab[s]) len_tab[s] = '0;
		foreach (len_count[l]) len_count[l] = 0;
		path_val  = '0;
		path_len  = 0;
		n_decoded = '0;
		sym_total = '0;
		ready     = 1'b0;
	end

	// Does a node exist at this depth along path q, and which symbol ends there.
	// Later codes in canonical order override earlier ones on a clash.
	function automatic bit node_lookup(input logic [31:0] q, input int unsigned depth,
			output int hit_sym);
		bit          found;
		int unsigned base;
		logic [31:0] mask;
		logic [31:0] c;
		found   = 1'b0;
		base    = 0;
		hit_sym = -1;
		for (int unsigned l = 1; l <= MAX_LEN; l++) begin
			mask = (l == 32) ? 32'hFFFF_FFFF : ((32'd1 << l) - 32'd1);
			for (int unsigned k = 0; k < len_count[l]; k++) begin
				c = (first_code[l] + k) & mask;
				if (l >= depth && (c >> (l - depth)) == q) found = 1'b1;
				if (l == depth && c == q && base + k < ALPHA) hit_sym = order_sym[base + k];
			end
			base += len_count[l];
		end
		return found;
	endfunction

	function automatic void build_canonical();
		int unsigned present;
		int unsigned pos;
		int unsigned prev;
		int unsigned l_eff;
		bit          lone;
		logic [31:0] code;
		present = 0;
		foreach (len_tab[s]) if (len_tab[s] != 0) present++;
		lone = (present == 1);
		foreach (len_count[l]) begin
			len_count[l]  = 0;
			first_code[l] = '0;
		end
		foreach (order_sym[s]) order_sym[s] = '0;
		pos = 0;
		for (int unsigned l = 1; l <= MAX_LEN; l++) begin
			for (int unsigned s = 0; s < ALPHA; s++) begin
				l_eff = len_tab[s];
				if (l_eff == 0) continue;
				// a single symbol still needs one bit
				if (lone) l_eff = 1;
				if (l_eff == l && pos < ALPHA) begin
					order_sym[pos] = s[SYM_W-1:0];
					pos++;
					len_count[l]++;
				end
			end
		end
		code = '0;
		prev = 0;
		for (int unsigned l = 1; l <= MAX_LEN; l++) begin
			if (len_count[l] == 0) continue;
			if (prev != 0 && l > prev) code = code << (l - prev);
			prev = l;
			first_code[l] = code;
			code = code + len_count[l];
		end
		path_val  = '0;
		path_len  = 0;
		n_decoded = '0;
		ready     = (present != 0);
	endfunction

	// Apply one accepted item to the model; queue the symbols it yields
	function automatic void decode_item(input opcode_t op, input logic [IDX_W-1:0] idx,
			input logic [LEN_IN_W-1:0] ln, input logic [BYTE_W-1:0] dbyte);
		dec_out_t    outs [$];
		dec_out_t    r;
		logic [31:0] q;
		int unsigned depth;
		int          hit;
		case (op)
			OP_CLEAR: begin
				foreach (len_tab[s]) len_tab[s] = '0;
			end
			OP_SET_LEN: begin
				len_tab[idx] = (ln > MAX_LEN) ? LEN_IN_W'(MAX_LEN) : ln;
			end
			OP_START: begin
				build_canonical();
				n_builds++;
			end
			OP_DATA: begin
				if (ready) begin
					for (int b = 7; b >= 0; b--) begin
						if (n_decoded >= sym_total) break;
						depth = path_len + 1;
						if (depth > MAX_LEN) continue;
						q = {path_val[30:0], dbyte[b]};
						// dead bit: drop it, stay put
						if (!node_lookup(q, depth, hit)) continue;
						path_val = q;
						path_len = depth;
						if (hit >= 0) begin
							n_decoded++;
							r.sym  = hit[SYM_W-1:0];
							r.last = 1'b0;
							r.done = (n_decoded == sym_total);
							outs.push_back(r);
							path_val = '0;
							path_len = 0;
						end
					end
					if (outs.size() != 0) outs[outs.size()-1].last = 1'b1;
					foreach (outs[i]) symbols_due.push_back(outs[i]);
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
			input logic [TOTAL_W-1:0] want);
		n_errs++;
		if (n_errs <= 40) begin
			$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		end
	endtask

	// ---------------------------------------------------------------
	// Input side: feeds items from the send queue, bursts of idle
	// ---------------------------------------------------------------
	int unsigned send_gap;
	chd_item_t   nxt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= OP_CLEAR;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_item(opcode_t'(s_tuser), s_tdata[7:0], s_tdata[13:8], s_tdata[21:14]);
				n_items++;
			end
			// a held item stays put until taken
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (items_to_send.size() != 0 && !(idle_on && $urandom_range(0, 7) == 0)) begin
					nxt = items_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, nxt.dbyte, nxt.ln, nxt.idx};
					s_tuser  <= nxt.op;
				end else begin
					s_tvalid <= 1'b0;
					if (idle_on && items_to_send.size() != 0) send_gap <= $urandom_range(0, 5);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Output side: checks symbols, random stalls, one long hold-off
	// ---------------------------------------------------------------
	int unsigned hold_left, stall_left;
	dec_out_t    head;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			hold_left  <= 0;
			stall_left <= 0;
			hold_ack   <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (symbols_due.size() == 0) begin
					report_mismatch("symbol with none expected", m_tdata, '0);
				end else begin
					head = symbols_due.pop_front();
					if (m_tdata !== head.sym) report_mismatch("symbol", m_tdata, head.sym);
					if (m_tlast !== head.last) report_mismatch("last_of_byte", m_tlast, head.last);
					if (m_tuser[0] !== head.done) report_mismatch("stream_done", m_tuser, head.done);
				end
			end
			// hold-off starts once a symbol is waiting, so the block backs up
			if (hold_ack != hold_req && m_tvalid) begin
				hold_ack  <= hold_req;
				hold_left <= HOLD_CYCLES;
				m_tready  <= 1'b0;
				n_holds++;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				stall_left <= $urandom_range(0, 5);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic void push_item(input opcode_t op, input logic [IDX_W-1:0] idx,
			input logic [LEN_IN_W-1:0] ln, input logic [BYTE_W-1:0] dbyte);
		chd_item_t it;
		it.op    = op;
		it.idx   = idx;
		it.ln    = ln;
		it.dbyte = dbyte;
		items_to_send.push_back(it);
		n_pushed++;
	endfunction

	// Everything sent, every symbol seen, then room for a build to finish
	task automatic wait_quiet();
		do @(negedge clk); while (items_to_send.size() != 0 || s_tvalid || symbols_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_total(input logic [TOTAL_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sym_total = v;
		n_cfg++;
		@(negedge clk);
	endtask

	// Mostly complete prefix codes (split a leaf until done), some lone symbols,
	// some raw noise; then a start and a handful of data bytes.
	task automatic queue_sequence(input int unsigned max_bytes);
		int unsigned lens [$];
		bit          used [ALPHA];
		int unsigned pick;
		int unsigned s;
		if ($urandom_range(0, 4) != 0) begin
			if ($urandom_range(0, 9) == 0) begin
				lens.push_back($urandom_range(1, 63));
			end else begin
				lens.push_back(1);
				lens.push_back(1);
				repeat ($urandom_range(0, 12)) begin
					pick = $urandom_range(0, lens.size() - 1);
					if (lens[pick] < 12) begin
						lens[pick]++;
						lens.push_back(lens[pick]);
					end
				end
			end
			if ($urandom_range(0, 4) != 0) push_item(OP_CLEAR, $urandom, $urandom, $urandom);
			foreach (lens[i]) begin
				do s = $urandom_range(0, ALPHA - 1); while (used[s]);
				used[s] = 1'b1;
				push_item(OP_SET_LEN, s, lens[i], $urandom);
			end
			// now and then knock one symbol out again
			if ($urandom_range(0, 5) == 0) push_item(OP_SET_LEN, $urandom, '0, $urandom);
		end else begin
			repeat ($urandom_range(2, 10)) begin
				push_item(opcode_t'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
			end
		end
		push_item(OP_START, $urandom, $urandom, $urandom);
		repeat ($urandom_range(2, max_bytes)) push_item(OP_DATA, $urandom, $urandom, $urandom);
	endtask

	initial begin
		logic [TOTAL_W-1:0] tot;
		int unsigned        goal;
		idle_on  = 1'b1;
		hold_req = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Total of zero: data before any build, then a build that may not emit
		write_total('0);
		push_item(OP_DATA, 8'h00, 6'd0, 8'hA5);
		push_item(OP_SET_LEN, 8'h11, 6'd5, 8'h00);
		push_item(OP_START, 8'h00, 6'd0, 8'h00);
		push_item(OP_DATA, 8'h00, 6'd0, 8'h5A);
		wait_quiet();

		// Largest total. Lone symbol gets code '0'; ones are dead bits.
		write_total({TOTAL_W{1'b1}});
		push_item(OP_DATA, 8'h00, 6'd0, 8'h3C);
		// clearing lengths leaves the built code in use
		push_item(OP_CLEAR, 8'h00, 6'd0, 8'h00);
		push_item(OP_DATA, 8'h00, 6'd0, 8'h00);
		// empty table: nothing decodes
		push_item(OP_START, 8'h00, 6'd0, 8'h00);
		push_item(OP_DATA, 8'h00, 6'd0, 8'hFF);
		// 0,10,110 plus one 32-bit code 1110...0; oversize length clamps to 32
		push_item(OP_SET_LEN, 8'h00, 6'd63, 8'h00);
		push_item(OP_SET_LEN, 8'hFF, 6'd1, 8'h00);
		push_item(OP_SET_LEN, 8'h80, 6'd2, 8'h00);
		push_item(OP_SET_LEN, 8'h81, 6'd3, 8'h00);
		push_item(OP_START, 8'h00, 6'd0, 8'h00);
		push_item(OP_DATA, 8'h00, 6'd0, 8'hE0);
		push_item(OP_DATA, 8'h00, 6'd0, 8'h00);
		push_item(OP_DATA, 8'h00, 6'd0, 8'h00);
		push_item(OP_DATA, 8'h00, 6'd0, 8'h00);
		push_item(OP_DATA, 8'h00, 6'd0, 8'h6D);
		wait_quiet();

		// Small total, clashing one-bit codes; the byte after the limit yields nothing
		write_total(48'd5);
		push_item(OP_CLEAR, 8'h00, 6'd0, 8'h00);
		push_item(OP_SET_LEN, 8'h01, 6'd1, 8'h00);
		push_item(OP_SET_LEN, 8'h02, 6'd1, 8'h00);
		push_item(OP_SET_LEN, 8'h03, 6'd1, 8'h00);
		push_item(OP_START, 8'h00, 6'd0, 8'h00);
		push_item(OP_DATA, 8'h00, 6'd0, 8'h55);
		push_item(OP_DATA, 8'h00, 6'd0, 8'h0F);

		// Random phases, each with its own total; the last runs without idling
		for (int unsigned p = 0; p < PHASES; p++) begin
			wait_quiet();
			idle_on = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 2))
				0: begin
					tot = {TOTAL_W{1'b1}};
				end
				1: begin
					tot = {$urandom, $urandom};
				end
				default: begin
					tot = $urandom_range(10, 60);
				end
			endcase
			if (p == PHASES - 1) tot = {TOTAL_W{1'b1}};
			write_total(tot);
			goal = n_pushed + RANDOM_ITEMS / PHASES;
			if (p == 1) begin
				hold_req = hold_req + 1;
				queue_sequence(12);
			end
			while (n_pushed < goal) queue_sequence(8);
		end
		wait_quiet();

		$display("decoder run: %0d items taken, %0d symbols compared, %0d code builds",
			n_items, n_results, n_builds);
		$display("%0d total-count writes, %0d long output hold-offs, %0d mismatches",
			n_cfg, n_holds, n_errs);
		if (n_errs == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("timeout: decoder run did not drain");
		$display("CHECK FAILED");
		$finish;
	end

endmodule
